>>> sv/rpst_pkg.sv
`default_nettype none

package rpst_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int CAPACITY_MAX = 4096;
    localparam int KEY_BITS_DEF = 48;

    localparam int ADDR_KEY_W = 48;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int LIVE_W     = 9;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

`default_nettype wire

>>> sv/rpst_slot_ram.sv
`default_nettype none

module rpst_slot_ram
    import rpst_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = KEY_BITS_DEF + 1
) (
    input  wire logic                     i_clk,
    input  wire t_ram_ctl                 i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/rpst_ctrl.sv
`default_nettype none

module rpst_ctrl
    import rpst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int ENT_W   = KEY_BITS + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [ADDR_KEY_W-1:0] i_address_key,
    output t_ram_ctl                   o_ram_ctl,
    output logic      [IDX_W-1:0]      o_ram_waddr,
    output logic      [ENT_W-1:0]      o_ram_wdata,
    output logic      [IDX_W-1:0]      o_ram_raddr,
    input  wire logic [ENT_W-1:0]      i_ram_rdata,
    output logic                       o_done,
    output logic                       o_found,
    output logic      [STAT_W-1:0]     o_status,
    output logic      [LIVE_W-1:0]     o_live_count
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    t_state r_state, n_state;

    logic [IDX_W-1:0]      r_idx;
    logic                  r_issue_done;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [OP_W-1:0]       r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_hit_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic [CNT_W-1:0]      r_count;
    logic                  r_done;
    logic                  r_found;
    logic [STAT_W-1:0]     r_status;
    logic [LIVE_W-1:0]     r_live;

    logic [63:0]           key_ext;
    logic                  accept;
    logic                  ent_valid;
    logic                  ent_match;
    logic                  do_add;
    logic                  do_remove;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W+LIVE_W-1:0] count_ext;
    logic [STAT_W-1:0]     n_status;

    assign key_ext   = {{(64 - ADDR_KEY_W){1'b0}}, i_address_key};
    assign accept    = i_start && (r_state == ST_IDLE);
    assign ent_valid = i_ram_rdata[KEY_BITS];
    assign ent_match = ent_valid && (i_ram_rdata[KEY_BITS-1:0] == r_key);
    assign do_add    = (r_op == OP_ADD) && r_free_found;
    assign do_remove = (r_op == OP_REMOVE) && r_hit_found;

    always_comb begin
        n_count = r_count;
        if (do_add) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign count_ext = (CNT_W + LIVE_W)'(n_count);

    always_comb begin
        n_status = STAT_OK;
        if ((r_op == OP_ADD) && !r_free_found) begin
            n_status = STAT_FULL;
        end else if ((r_op == OP_REMOVE) && !r_hit_found) begin
            n_status = STAT_ABSENT;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_ram_ctl   = '0;
        o_ram_waddr = r_idx;
        o_ram_wdata = '0;
        o_ram_raddr = r_idx;
        unique case (r_state)
            ST_CLEAR: begin
                o_ram_ctl.we = 1'b1;
            end
            ST_SCAN: begin
                o_ram_ctl.re = !r_issue_done;
            end
            ST_COMMIT: begin
                if (do_add) begin
                    o_ram_ctl.we = 1'b1;
                    o_ram_waddr  = r_free_idx;
                    o_ram_wdata  = {1'b1, r_key};
                end else if (do_remove) begin
                    o_ram_ctl.we = 1'b1;
                    o_ram_waddr  = r_hit_idx;
                    o_ram_wdata  = {1'b0, r_key};
                end
            end
            default: begin
                o_ram_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= (r_state == ST_COMMIT);
            r_cmp_vld <= o_ram_ctl.re;
            if (r_state == ST_CLEAR) begin
                r_idx <= r_idx + IDX_W'(1);
            end else if (accept) begin
                r_idx        <= '0;
                r_issue_done <= 1'b0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else if (o_ram_ctl.re) begin
                r_idx <= r_idx + IDX_W'(1);
                if (r_idx == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end
            end
            if (r_cmp_vld) begin
                if (ent_match && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                end
                if (!ent_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (r_state == ST_COMMIT) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (accept) begin
            r_op  <= i_operation;
            r_key <= key_ext[KEY_BITS-1:0];
        end
        if (r_cmp_vld && ent_match && !r_hit_found) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && !ent_valid && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
        if (r_state == ST_COMMIT) begin
            r_found  <= r_hit_found;
            r_status <= n_status;
            r_live   <= count_ext[LIVE_W-1:0];
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_status     = r_status;
    assign o_live_count = r_live;

endmodule

`default_nettype wire

>>> sv/pointer_root_set_table.sv
// A start taken while idle goes through the scan and commit states to the
// registered o_done strobe. One compare unit walks every slot of the
// single-read-port slot RAM, one slot per cycle; a new start is taken only while idle.
// Reset: synchronous, active low; a clearing pass over every slot follows,
// with busy high. The receiver cannot stall; o_done shows for one cycle.
`default_nettype none

module pointer_root_set_table
    import rpst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [ADDR_KEY_W-1:0] i_address_key,
    output logic                       o_done,
    output logic                       o_found,
    output logic      [STAT_W-1:0]     o_status,
    output logic      [LIVE_W-1:0]     o_live_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int ENT_W = KEY_BITS + 1;

    t_ram_ctl         ram_ctl;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    rpst_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rpst_ctrl #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_operation   (i_operation),
        .i_address_key (i_address_key),
        .o_ram_ctl     (ram_ctl),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_live_count  (o_live_count)
    );

endmodule

`default_nettype wire

>>> sv/rpst_checker.sv
`default_nettype none

module rpst_checker
    import rpst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic              o_found,
    input wire logic [STAT_W-1:0] o_status
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == STAT_OK || o_status == STAT_FULL
                    || o_status == STAT_ABSENT))
        else $error("status code out of range");

    a_absent_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == STAT_ABSENT) |-> !o_found)
        else $error("absent status with found set");

endmodule

bind pointer_root_set_table rpst_checker u_rpst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_found  (o_found),
    .o_status (o_status)
);

`default_nettype wire
